>>> sv/ate_pkg.sv
`timescale 1ns / 1ps
package ate_pkg;
    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_READ    = 3'd4,
        CMD_BSEARCH = 3'd5,
        CMD_LSEARCH = 3'd6,
        CMD_SORT    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_RUN  = 2'd1,
        FSM_DONE = 2'd2
    } t_fsm;

    // per-cycle operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_LOAD   = 3'd1,   // cell at sel takes key
        OP_SHUP   = 3'd2,   // cells take left neighbor, cell 0 takes key
        OP_SHDN   = 3'd3,   // cells at or above sel take right neighbor
        OP_SORTE  = 3'd4,   // compare-exchange even pairs
        OP_SORTO  = 3'd5    // compare-exchange odd pairs
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [IDX_W-1:0]     sel;
        logic [KEY_WIDTH-1:0] key;
        logic [CNT_W-1:0]     count;
    } t_cell_ctl;
endpackage

>>> sv/ate_cell.sv
`timescale 1ns / 1ps
module ate_cell (
    input  logic                          i_clk,
    input  ate_pkg::t_cell_ctl            i_ctl,
    input  logic [ate_pkg::IDX_W-1:0]     i_index,
    input  logic [ate_pkg::KEY_WIDTH-1:0] i_left,
    input  logic [ate_pkg::KEY_WIDTH-1:0] i_right,
    output logic [ate_pkg::KEY_WIDTH-1:0] o_key
);
    import ate_pkg::*;

    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [CNT_W-1:0]     w_idx;
    logic                 w_even, w_low, w_has_r, w_has_l;

    assign w_idx   = CNT_W'(i_index);
    assign w_even  = ~i_index[0];
    // pair partner exists below the count
    assign w_has_r = (w_idx + 1'b1) < i_ctl.count;
    assign w_has_l = (w_idx != '0) && (w_idx < i_ctl.count);
    assign w_low   = (i_ctl.op == OP_SORTE) ? w_even : ~w_even;

    always_comb begin
        n_key = r_key;
        case (i_ctl.op)
            OP_LOAD: if (i_index == i_ctl.sel) n_key = i_ctl.key;
            OP_SHUP: n_key = (i_index == '0) ? i_ctl.key : i_left;
            OP_SHDN: if (i_index >= i_ctl.sel) n_key = i_right;
            OP_SORTE, OP_SORTO: begin
                if (w_low) begin
                    if (w_has_r && r_key > i_right) n_key = i_right;
                end else begin
                    if (w_has_l && i_left > r_key) n_key = i_left;
                end
            end
            default: n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
endmodule

>>> sv/array_table_engine_core.sv
`timescale 1ns / 1ps
// Ordered table of up to CAPACITY unsigned keys held in a row of cells, one
// key per cell; cells pass keys to their neighbors, so insert-front and remove
// shift the whole row at once. A word is accepted while the engine is idle and
// then works in the run state until it finishes. Its result word then sits in
// an output register until taken, and the next word is accepted in the cycle
// after that, so the engine holds one word at a time. Append, insert,
// overwrite, remove and read do their work at once. Linear search walks the
// row one element per cycle and stops at a hit or at the end of the table.
// Binary search probes one element per cycle, up to log2(CAPACITY)+1 probes,
// and detects a miss once its bounds cross. Sort runs odd-even transposition,
// one pass per cycle, CAPACITY passes. The longest item is a linear-search
// miss on a full table.
module array_table_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_new_value,
    input  logic [3:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_found_index,
    output logic [31:0] o_value_out,
    output logic [4:0]  o_count_out
);
    import ate_pkg::*;

    t_fsm                 r_state, n_state;
    t_cmd                 r_cmd;
    logic [KEY_WIDTH-1:0] r_key;
    logic [IDX_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_step;
    logic signed [CNT_W+1:0] r_lo, r_hi, n_lo, n_hi;
    logic [1:0]           r_status, n_status;
    logic [IDX_W-1:0]     r_found, n_found;
    logic [KEY_WIDTH-1:0] r_value, n_value;
    logic                 w_finish;
    t_cell_ctl            w_ctl;
    logic [KEY_WIDTH-1:0] w_keys [CAPACITY];
    logic [CNT_W+1:0]     w_mid_s;
    logic [IDX_W-1:0]     w_mid, w_probe_i;
    logic [KEY_WIDTH-1:0] w_probe;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            ate_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_index (IDX_W'(g)),
                .i_left  ((g == 0) ? w_keys[0] : w_keys[(g == 0) ? 0 : g - 1]),
                .i_right ((g == CAPACITY - 1) ? w_keys[g]
                                              : w_keys[(g == CAPACITY - 1) ? g : g + 1]),
                .o_key   (w_keys[g])
            );
        end
    endgenerate

    // binary search midpoint; lo and hi stay in range while hi >= lo
    assign w_mid_s   = (CNT_W+2)'(r_lo + r_hi) >> 1;
    assign w_mid     = w_mid_s[IDX_W-1:0];
    assign w_probe_i = (r_cmd == CMD_BSEARCH) ? w_mid : r_step[IDX_W-1:0];
    assign w_probe   = w_keys[w_probe_i];

    assign o_ready = (r_state == FSM_IDLE);
    assign o_valid = (r_state == FSM_DONE);
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_value_out   = r_value;
    assign o_count_out   = r_count;

    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: if (i_valid)  n_state = FSM_RUN;
            FSM_RUN:  if (w_finish) n_state = FSM_DONE;
            FSM_DONE: if (i_ready)  n_state = FSM_IDLE;
            default:  n_state = FSM_IDLE;
        endcase
    end

    // working cycle: drive cells, update result
    always_comb begin
        w_finish  = 1'b1;
        w_ctl.op  = OP_HOLD;
        w_ctl.sel = r_pos;
        w_ctl.key = r_key;
        w_ctl.count = r_count;
        n_count  = r_count;
        n_status = r_status;
        n_found  = r_found;
        n_value  = r_value;
        n_lo     = r_lo;
        n_hi     = r_hi;
        if (r_state == FSM_RUN) begin
            case (r_cmd)
                CMD_APPEND, CMD_INSERT: begin
                    if (r_count >= CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.op  = (r_cmd == CMD_APPEND) ? OP_LOAD : OP_SHUP;
                        w_ctl.sel = r_count[IDX_W-1:0];
                        n_count   = r_count + 1'b1;
                    end
                end
                CMD_WRITE, CMD_REMOVE, CMD_READ: begin
                    if (CNT_W'(r_pos) >= r_count) begin
                        n_status = ST_BAD_INDEX;
                    end else begin
                        if (r_cmd != CMD_WRITE) n_value = w_keys[r_pos];
                        if (r_cmd == CMD_WRITE) w_ctl.op = OP_LOAD;
                        if (r_cmd == CMD_REMOVE) begin
                            w_ctl.op = OP_SHDN;
                            n_count  = r_count - 1'b1;
                        end
                    end
                end
                CMD_LSEARCH: begin
                    if (r_step >= r_count) begin
                        n_status = ST_NOT_FOUND;
                    end else if (w_probe == r_key) begin
                        n_found = w_probe_i;
                        n_value = w_probe;
                    end else begin
                        w_finish = 1'b0;
                    end
                end
                CMD_BSEARCH: begin
                    if (r_hi < r_lo) begin
                        n_status = ST_NOT_FOUND;
                    end else if (w_probe == r_key) begin
                        n_found = w_mid;
                        n_value = w_probe;
                    end else begin
                        w_finish = 1'b0;
                        if (w_probe > r_key)
                            n_hi = $signed({2'b00, CNT_W'(w_mid)}) - (CNT_W+2)'(1);
                        else
                            n_lo = $signed({2'b00, CNT_W'(w_mid)}) + (CNT_W+2)'(1);
                    end
                end
                CMD_SORT: begin
                    w_ctl.op = r_step[0] ? OP_SORTO : OP_SORTE;
                    w_finish = (r_step == CNT_W'(CAPACITY - 1));
                end
                default: w_finish = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        if (r_state == FSM_IDLE && i_valid) begin
            r_cmd    <= t_cmd'(i_command);
            r_key    <= i_new_value[KEY_WIDTH-1:0];
            r_pos    <= i_position[IDX_W-1:0];
            r_step   <= '0;
            r_lo     <= '0;
            r_hi     <= $signed({2'b00, r_count}) - (CNT_W+2)'(1);
            r_status <= ST_OK;
            r_found  <= '0;
            r_value  <= '0;
        end else if (r_state == FSM_RUN) begin
            r_step   <= r_step + 1'b1;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_status <= n_status;
            r_found  <= n_found;
            r_value  <= n_value;
        end
    end

    // count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY)) else $error("count over capacity");
    // count only changes during a working cycle
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != FSM_RUN) |=> $stable(r_count)) else $error("count moved");
    // full status leaves count at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> r_count == CNT_W'(CAPACITY))
        else $error("full with room");
endmodule

>>> verif/array_table_engine_core_tb.sv
`timescale 1ns / 1ps
module array_table_engine_core_tb;
    import ate_pkg::*;

    typedef struct {
        t_status     status;
        logic [3:0]  found_index;
        logic [31:0] value_out;
        logic [4:0]  count_out;
    } t_answer;

    // Table predictor plus queue of pending answers.
    class table_scoreboard;
        logic [31:0] keys [CAPACITY];
        int          fill;
        t_answer     pending [$];
        int          errors;

        function new();
            fill = 0;
            errors = 0;
            foreach (keys[k]) keys[k] = '0;
        endfunction

        function void note_word(t_cmd cmd, logic [31:0] key, logic [3:0] pos);
            t_answer a;
            int lo, hi, mid;
            logic [31:0] t;
            a.status = ST_OK;
            a.found_index = '0;
            a.value_out = '0;
            case (cmd)
                CMD_APPEND: begin
                    if (fill >= CAPACITY) a.status = ST_FULL;
                    else begin
                        keys[fill] = key;
                        fill++;
                    end
                end
                CMD_INSERT: begin
                    if (fill >= CAPACITY) a.status = ST_FULL;
                    else begin
                        for (int i = fill; i > 0; i--) keys[i] = keys[i-1];
                        keys[0] = key;
                        fill++;
                    end
                end
                CMD_WRITE: begin
                    if (pos >= fill) a.status = ST_BAD_INDEX;
                    else keys[pos] = key;
                end
                CMD_REMOVE: begin
                    if (pos >= fill) a.status = ST_BAD_INDEX;
                    else begin
                        a.value_out = keys[pos];
                        for (int i = pos; i + 1 < fill; i++) keys[i] = keys[i+1];
                        fill--;
                    end
                end
                CMD_READ: begin
                    if (pos >= fill) a.status = ST_BAD_INDEX;
                    else a.value_out = keys[pos];
                end
                CMD_BSEARCH: begin
                    lo = 0;
                    hi = fill - 1;
                    a.status = ST_NOT_FOUND;
                    while (hi >= lo) begin
                        mid = (lo + hi) / 2;
                        if (keys[mid] == key) begin
                            a.status = ST_OK;
                            a.found_index = mid[3:0];
                            a.value_out = key;
                            break;
                        end
                        if (keys[mid] > key) hi = mid - 1;
                        else lo = mid + 1;
                    end
                end
                CMD_LSEARCH: begin
                    a.status = ST_NOT_FOUND;
                    for (int i = 0; i < fill; i++) begin
                        if (keys[i] == key) begin
                            a.status = ST_OK;
                            a.found_index = i[3:0];
                            a.value_out = key;
                            break;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i + 1 < fill; i++)
                        for (int j = i + 1; j < fill; j++)
                            if (keys[i] > keys[j]) begin
                                t = keys[i];
                                keys[i] = keys[j];
                                keys[j] = t;
                            end
                end
            endcase
            a.count_out = fill[4:0];
            pending.push_back(a);
        endfunction

        function void check_word(logic [1:0] st, logic [3:0] fi, logic [31:0] vo,
                                 logic [4:0] co);
            t_answer a;
            if (pending.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            a = pending.pop_front();
            if (st !== a.status) begin
                $error("status exp %0d got %0d", a.status, st);
                errors++;
            end
            if (fi !== a.found_index) begin
                $error("found_index exp %0d got %0d", a.found_index, fi);
                errors++;
            end
            if (vo !== a.value_out) begin
                $error("value_out exp %h got %h", a.value_out, vo);
                errors++;
            end
            if (co !== a.count_out) begin
                $error("count_out exp %0d got %0d", a.count_out, co);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_command;
    logic [31:0] i_new_value;
    logic [3:0]  i_position;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [3:0]  o_found_index;
    logic [31:0] o_value_out;
    logic [4:0]  o_count_out;

    table_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int cycles;

    array_table_engine_core DUT (.*);

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Check result words at the rising edge and stop on a timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready)
            sb.check_word(o_status, o_found_index, o_value_out, o_count_out);
        if (cycles > 400000) begin
            $display("[array_table_engine_core] ERROR");
            $finish;
        end
    end

    // Randomly stall the receiver, changing at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Drive one word: optional idle gap, then hold it until accepted.
    // Valid stays high on return; the caller drops it when the bus goes idle.
    task automatic send_word(t_cmd cmd, logic [31:0] key, logic [3:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_new_value <= key;
        i_position <= pos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(cmd, key, pos);
        @(negedge i_clk);
    endtask

    // Pick keys from a small pool often so searches hit and duplicates arise.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return 32'hFFFF_FFF8 | $urandom_range(7);
            default: return $urandom();
        endcase
    endfunction

    // Bias toward fill commands while short and removes while long.
    task automatic random_word();
        t_cmd cmd;
        int r;
        r = $urandom_range(99);
        if (r < 22) cmd = (sb.fill < 12 || $urandom_range(1)) ? CMD_APPEND : CMD_REMOVE;
        else if (r < 32) cmd = CMD_INSERT;
        else if (r < 44) cmd = CMD_WRITE;
        else if (r < 60) cmd = CMD_REMOVE;
        else if (r < 70) cmd = CMD_READ;
        else if (r < 82) cmd = CMD_BSEARCH;
        else if (r < 92) cmd = CMD_LSEARCH;
        else cmd = CMD_SORT;
        send_word(cmd, pick_key(),
                  (sb.fill > 0 && $urandom_range(4) != 0) ?
                  4'($urandom_range(sb.fill - 1)) : 4'($urandom()));
    endtask

    initial begin
        sb = new();
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_command = CMD_APPEND;
        i_new_value = '0;
        i_position = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        i_ready <= 1'b1;

        // Directed: empty table, fill to full, extremes, searches, sort.
        send_word(CMD_READ, 32'h0, 4'd0);
        send_word(CMD_REMOVE, 32'h0, 4'd15);
        send_word(CMD_BSEARCH, 32'h0, 4'd0);
        send_word(CMD_LSEARCH, 32'h0, 4'd0);
        send_word(CMD_SORT, 32'h0, 4'd0);
        send_word(CMD_APPEND, 32'hFFFF_FFFF, 4'd0);
        send_word(CMD_SORT, 32'h0, 4'd0);
        for (int i = 0; i < 15; i++)
            send_word(i[0] ? CMD_INSERT : CMD_APPEND, 32'h5555_5555 ^ i, 4'hF);
        send_word(CMD_APPEND, 32'h0, 4'd0);
        send_word(CMD_INSERT, 32'h1, 4'd0);
        send_word(CMD_BSEARCH, 32'h5555_5555, 4'd0);
        send_word(CMD_SORT, 32'h0, 4'd0);
        send_word(CMD_BSEARCH, 32'hFFFF_FFFF, 4'd0);
        send_word(CMD_LSEARCH, 32'h5555_5554, 4'd0);
        send_word(CMD_WRITE, 32'hAAAA_AAAA, 4'd15);
        send_word(CMD_READ, 32'h0, 4'd15);
        send_word(CMD_REMOVE, 32'h0, 4'd0);
        i_valid <= 1'b0;

        // Hold off until every pending answer has come back.
        while (sb.pending.size() != 0) @(negedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            for (int n = 0; n < 430; n++) random_word();
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[array_table_engine_core] OK");
        else
            $display("[array_table_engine_core] ERROR");
        $finish;
    end
endmodule

>>> array_table_engine_core.f
sv/ate_pkg.sv
sv/ate_cell.sv
sv/array_table_engine_core.sv
verif/array_table_engine_core_tb.sv
